// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks used by the path validator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HPV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define HPV_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/hpv_pkg.sv
// ----------------------------------------------------------------------------
// hpv_pkg
// status codes and result struct of the hierarchical path validator
// ----------------------------------------------------------------------------
package hpv_pkg;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_TOO_LONG = 3'd1,
        STAT_NO_LEAD  = 3'd2,
        STAT_DOUBLE   = 3'd3,
        STAT_DOTS     = 3'd4,
        STAT_BAD      = 3'd5,
        STAT_EMPTY    = 3'd6,
        STAT_END_DOTS = 3'd7
    } status_t;

    typedef struct packed {
        logic       emit;
        status_t    status;
        logic [7:0] fail_index;
    } res_t;

endpackage

// File: rtl/core/hpv_in_stage.sv
// ----------------------------------------------------------------------------
// hpv_in_stage
// input register for path bytes, frees up as soon as the byte moves on
// ----------------------------------------------------------------------------
module hpv_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       advance,
    output logic       s1_valid,
    output logic [7:0] s1_ch
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg <= ch;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_ch    = ch_reg;

endmodule

// File: rtl/core/hpv_scanner.sv
// ----------------------------------------------------------------------------
// hpv_scanner
// per-path scan state, length count and first failure; decides each result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpv_scanner
#(
    parameter int MAX_PATH_LEN = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    output hpv_pkg::res_t     res
);

    localparam int CW     = $clog2(MAX_PATH_LEN);
    localparam int TL_IDX = (MAX_PATH_LEN - 1 > 255) ? 255 : MAX_PATH_LEN - 1;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef enum logic [1:0] {
        SC_START     = 2'd0,
        SC_MIDDLE    = 2'd1,
        SC_SLASH     = 2'd2,
        SC_SLASHDOTS = 2'd3
    } scan_t;

    scan_t            state_reg;
    scan_t            state_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    hpv_pkg::status_t code_reg;
    hpv_pkg::status_t code_next;
    logic [7:0]       pos_reg;
    logic [7:0]       pos_next;
    logic             slash_reg;
    logic             slash_next;
    logic [CW:0]      cnt_inc;
    logic             ch_ok;
    logic             is_slash;
    logic             is_dot;

    function automatic logic [7:0] sat8(input logic [CW-1:0] p);
        logic [CW+7:0] w;
        w = (CW+8)'(p);
        if (w > (CW+8)'(255))
        begin
            return 8'hff;
        end
        return w[7:0];
    endfunction

    assign is_slash = (ch == CH_SLASH);
    assign is_dot   = (ch == CH_DOT);
    assign ch_ok    = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h30 && ch <= 8'h39) ||
                      ch == CH_DASH || ch == CH_UNDER || is_dot || is_slash;
    assign cnt_inc  = (CW+1)'(cnt_reg) + (CW+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        pos_next       = pos_reg;
        slash_next     = slash_reg;
        res.emit       = 1'b0;
        res.status     = hpv_pkg::STAT_OK;
        res.fail_index = '0;

        if (ch != 8'h00)
        begin
            // scan state and failure position freeze once a failure is held
            if (code_reg == hpv_pkg::STAT_OK)
            begin
                case (state_reg)
                    SC_START:
                    begin
                        if (!is_slash)
                            code_next = hpv_pkg::STAT_NO_LEAD;
                        else
                            state_next = SC_SLASH;
                    end
                    SC_SLASH:
                    begin
                        if (is_dot)
                            state_next = SC_SLASHDOTS;
                        else if (is_slash)
                            code_next = hpv_pkg::STAT_DOUBLE;
                        else if (!ch_ok)
                            code_next = hpv_pkg::STAT_BAD;
                        else
                            state_next = SC_MIDDLE;
                    end
                    SC_MIDDLE:
                    begin
                        if (is_slash)
                            state_next = SC_SLASH;
                        else if (!ch_ok)
                            code_next = hpv_pkg::STAT_BAD;
                    end
                    default:
                    begin
                        if (is_slash)
                            code_next = hpv_pkg::STAT_DOTS;
                        else if (is_dot)
                            state_next = SC_SLASHDOTS;
                        else if (!ch_ok)
                            code_next = hpv_pkg::STAT_BAD;
                        else
                            state_next = SC_MIDDLE;
                    end
                endcase
                if (code_next != hpv_pkg::STAT_OK)
                begin
                    pos_next = sat8(cnt_reg);
                end
            end
            slash_next = is_slash;
            cnt_next   = cnt_inc[CW-1:0];
            // length limit hit without terminator
            if (cnt_inc == (CW+1)'(MAX_PATH_LEN))
            begin
                res.emit       = 1'b1;
                res.status     = hpv_pkg::STAT_TOO_LONG;
                res.fail_index = 8'(TL_IDX);
            end
        end
        else
        begin
            res.emit = 1'b1;
            if (cnt_reg == '0)
            begin
                res.status = hpv_pkg::STAT_EMPTY;
            end
            else if (code_reg == hpv_pkg::STAT_NO_LEAD)
            begin
                res.status = hpv_pkg::STAT_NO_LEAD;
            end
            else if (slash_reg)
            begin
                res.status     = hpv_pkg::STAT_BAD;
                res.fail_index = sat8(cnt_reg - CW'(1));
            end
            else if (code_reg != hpv_pkg::STAT_OK)
            begin
                res.status     = code_reg;
                res.fail_index = pos_reg;
            end
            else if (state_reg == SC_SLASHDOTS)
            begin
                res.status     = hpv_pkg::STAT_END_DOTS;
                res.fail_index = sat8(cnt_reg - CW'(1));
            end
        end

        // every result restarts the scanner for the next path
        if (res.emit)
        begin
            state_next = SC_START;
            cnt_next   = '0;
            code_next  = hpv_pkg::STAT_OK;
            pos_next   = '0;
            slash_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_START;
            cnt_reg   <= '0;
            code_reg  <= hpv_pkg::STAT_OK;
            pos_reg   <= '0;
            slash_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
            pos_reg   <= pos_next;
            slash_reg <= slash_next;
        end
    end

    `HPV_ASSERT(a_cnt_below_max, (CW+1)'(cnt_reg) < (CW+1)'(MAX_PATH_LEN), "count at limit")
    `HPV_ASSERT(a_clear_after_emit, step && res.emit |=> cnt_reg == '0 && code_reg == hpv_pkg::STAT_OK, "not cleared after result")
    `HPV_ASSERT(a_fail_frozen, code_reg != hpv_pkg::STAT_OK && !(step && res.emit) |=> code_reg == $past(code_reg) && pos_reg == $past(pos_reg), "held failure changed")
    `HPV_ASSERT_NEVER(a_pos_without_fail, code_reg == hpv_pkg::STAT_OK && pos_reg != '0, "failure position without failure")

endmodule

// File: rtl/core/hpv_out_stage.sv
// ----------------------------------------------------------------------------
// hpv_out_stage
// result register holding status and failure index until taken
// ----------------------------------------------------------------------------
module hpv_out_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  hpv_pkg::res_t res,
    output logic          slot_free,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    status,
    output logic [7:0]    fail_index
);

    logic       valid_reg;
    logic       valid_next;
    logic [2:0] status_reg;
    logic [7:0] index_reg;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= res.status;
            index_reg  <= res.fail_index;
        end
    end

    assign out_valid  = valid_reg;
    assign status     = status_reg;
    assign fail_index = index_reg;

endmodule

// File: rtl/core/hierarchical_path_validator.sv
// ----------------------------------------------------------------------------
// hierarchical_path_validator
// checks a zero-terminated path arriving one byte per item and reports
// one status with the index of the first failure per path
// ----------------------------------------------------------------------------
//  channel  | signals                       | item
//  ---------+-------------------------------+------------------------------
//  input    | in_valid, in_ready, ch        | one path byte, zero ends path
//  output   | out_valid, out_ready, status, | one result per finished or
//           | fail_index                    | over-long path
//
// one byte per cycle unless a held result stalls it; the scanner update is one short step
// between the input register and the result register
// a path's result is registered as its ending byte leaves the input register
// reset clears the scanner and both stage valids, no clearing pass
// a held result stalls only a byte that would make a new result
module hierarchical_path_validator
#(
    parameter int MAX_PATH_LEN = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] fail_index
);

    logic          s1_valid;
    logic [7:0]    s1_ch;
    logic          advance;
    logic          slot_free;
    hpv_pkg::res_t res;

    // a byte that yields no result moves on even while a result waits
    assign advance = s1_valid && (!res.emit || slot_free);

    hpv_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ch       (ch),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_ch    (s1_ch)
    );

    hpv_scanner #(.MAX_PATH_LEN(MAX_PATH_LEN)) u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ch    (s1_ch),
        .res   (res)
    );

    hpv_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res.emit),
        .res        (res),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .fail_index (fail_index)
    );

endmodule
